[rtl/frg_pkg.sv]
// Package for the fraction reducer: sequencer state type and fixed result widths.
// Used by frg_out_if.sv, fraction_reduce_by_gcd.sv and the testbench; depends on nothing.
package frg_pkg;

    // Width of each reduced result field on the output channel.
    localparam int OUT_W = 32;

    // Sequencer states: wait for a beat, run Euclid, divide each part, present result.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_OUT
    } t_frg_state;

endpackage

[rtl/frg_in_if.sv]
// Input channel of the fraction reducer: valid/ready handshake and the fraction operands.
// Standalone interface; the width follows the operand width of the block.
interface frg_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] numerator;
    logic [DATA_WIDTH-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

[rtl/frg_out_if.sv]
// Output channel of the fraction reducer: valid/ready handshake and the reduced fraction.
// Depends on frg_pkg for the result field width.
interface frg_out_if;
    logic                       valid;
    logic                       ready;
    logic [frg_pkg::OUT_W-1:0]  reduced_numerator;
    logic [frg_pkg::OUT_W-1:0]  reduced_denominator;
    logic                       zero_operand_error;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output zero_operand_error, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input zero_operand_error, output ready);
endinterface

[rtl/fraction_reduce_by_gcd.sv]
// Fraction reducer: Euclid's gcd by repeated remainder, then both parts divided by the gcd.
// A zero operand goes straight to the result beat; else the Euclid remainder steps, then the
// numerator and denominator divisions run one after another, since one radix-2 divider does every division.
// Throughput: one beat at a time; ready again the cycle after the result beat is taken.
// Reset: synchronous, active low; returns the sequencer to idle with no result pending.
// Depends on frg_pkg, frg_in_if and frg_out_if.
module fraction_reduce_by_gcd #(
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frg_in_if.sink     i_item,
    frg_out_if.source  o_result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam int OUT_W = frg_pkg::OUT_W;

    frg_pkg::t_frg_state r_state;
    frg_pkg::t_frg_state n_state;

    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] r_res_num;
    logic [DATA_WIDTH-1:0] r_res_den;
    logic                  r_err;

    logic                  in_beat;
    logic                  out_beat;
    logic                  zero_in;
    logic                  div_last;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] step_rem;
    logic [DATA_WIDTH-1:0] step_quo;
    logic [DATA_WIDTH+OUT_W-1:0] ext_num;
    logic [DATA_WIDTH+OUT_W-1:0] ext_den;

    // Handshake events and the zero operand check on the incoming beat.
    assign in_beat  = i_item.valid && i_item.ready;
    assign out_beat = o_result.valid && o_result.ready;
    assign zero_in  = (i_item.numerator == '0) || (i_item.denominator == '0);
    assign div_last = (r_cnt == CNT_W'(DATA_WIDTH - 1));

    // One restoring divider step: shift in the next dividend bit and try the subtraction.
    assign rem_sh   = {r_rem, r_quo[DATA_WIDTH-1]};
    assign diff     = rem_sh - {1'b0, r_div};
    assign fits     = !diff[DATA_WIDTH];
    assign step_rem = fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    assign step_quo = {r_quo[DATA_WIDTH-2:0], fits};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frg_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = zero_in ? frg_pkg::ST_OUT : frg_pkg::ST_GCD;
                end
            end
            frg_pkg::ST_GCD: begin
                if (div_last && (step_rem == '0)) begin
                    n_state = frg_pkg::ST_DIV_NUM;
                end
            end
            frg_pkg::ST_DIV_NUM: begin
                if (div_last) begin
                    n_state = frg_pkg::ST_DIV_DEN;
                end
            end
            frg_pkg::ST_DIV_DEN: begin
                if (div_last) begin
                    n_state = frg_pkg::ST_OUT;
                end
            end
            frg_pkg::ST_OUT: begin
                if (out_beat) begin
                    n_state = frg_pkg::ST_IDLE;
                end
            end
            default: n_state = frg_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs follow the state alone.
    always_comb begin
        i_item.ready   = (r_state == frg_pkg::ST_IDLE);
        o_result.valid = (r_state == frg_pkg::ST_OUT);
    end

    // Results are cut or zero-extended to the output field width.
    assign ext_num = {{OUT_W{1'b0}}, r_res_num};
    assign ext_den = {{OUT_W{1'b0}}, r_res_den};
    assign o_result.reduced_numerator   = ext_num[OUT_W-1:0];
    assign o_result.reduced_denominator = ext_den[OUT_W-1:0];
    assign o_result.zero_operand_error  = r_err;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frg_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == frg_pkg::ST_GCD) || (r_state == frg_pkg::ST_DIV_NUM) ||
                (r_state == frg_pkg::ST_DIV_DEN)) begin
                r_cnt <= div_last ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Datapath: load operands, step the shared divider, and reload it between divisions.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            frg_pkg::ST_IDLE: begin
                if (in_beat) begin
                    r_num <= i_item.numerator;
                    r_den <= i_item.denominator;
                    r_rem <= '0;
                    r_err <= zero_in;
                    if (zero_in) begin
                        r_res_num <= '0;
                        r_res_den <= '0;
                    end
                    // Larger operand is the first dividend.
                    if (i_item.numerator < i_item.denominator) begin
                        r_quo <= i_item.denominator;
                        r_div <= i_item.numerator;
                    end else begin
                        r_quo <= i_item.numerator;
                        r_div <= i_item.denominator;
                    end
                end
            end
            frg_pkg::ST_GCD: begin
                if (div_last) begin
                    r_rem <= '0;
                    if (step_rem == '0) begin
                        // Divisor is the gcd; it stays loaded for the numerator division.
                        r_quo <= r_num;
                    end else begin
                        r_quo <= r_div;
                        r_div <= step_rem;
                    end
                end else begin
                    r_rem <= step_rem;
                    r_quo <= step_quo;
                end
            end
            frg_pkg::ST_DIV_NUM: begin
                if (div_last) begin
                    r_res_num <= step_quo;
                    r_rem     <= '0;
                    r_quo     <= r_den;
                end else begin
                    r_rem <= step_rem;
                    r_quo <= step_quo;
                end
            end
            frg_pkg::ST_DIV_DEN: begin
                if (div_last) begin
                    r_res_den <= step_quo;
                end else begin
                    r_rem <= step_rem;
                    r_quo <= step_quo;
                end
            end
            frg_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // One beat at a time: no new input while a result is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_item.ready)
        else $error("input ready while a result is pending");

    // An accepted beat always leaves idle, so input ready drops in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input ready right after an accepted beat");

    // The error result carries zeros in both parts.
    a_error_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.zero_operand_error) |->
        (o_result.reduced_numerator == '0) && (o_result.reduced_denominator == '0))
        else $error("error result with nonzero parts");

    // The shared divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == frg_pkg::ST_GCD) || (r_state == frg_pkg::ST_DIV_NUM) ||
         (r_state == frg_pkg::ST_DIV_DEN)) |-> (r_div != '0))
        else $error("divider running with zero divisor");
`endif

endmodule

[sim/fraction_reduce_by_gcd_test.sv]
// Self-checking testbench for fraction_reduce_by_gcd: drives fractions with random gaps and
// stalls, predicts each reduced fraction with Euclid's gcd, and checks every result beat.
// Depends on frg_pkg, frg_in_if, frg_out_if and the fraction_reduce_by_gcd RTL.
module fraction_reduce_by_gcd_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W        = frg_pkg::OUT_W;
    localparam int W           = 32;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 64;
    // The limit allows for the slowest fraction plus long gaps on both sides.
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [W-1:0] numerator;
        logic [W-1:0] denominator;
    } t_fraction;

    typedef struct packed {
        logic [OUT_W-1:0] reduced_numerator;
        logic [OUT_W-1:0] reduced_denominator;
        logic             zero_operand_error;
    } t_reduced;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    frg_in_if #(.DATA_WIDTH(W)) item_ch();
    frg_out_if                  result_ch();

    fraction_reduce_by_gcd #(
        .DATA_WIDTH(W)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    t_fraction   pending_fractions[$];
    t_reduced    expected_reductions[$];
    int unsigned fib[48];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        item_taken = 1'b0;
    logic        result_taken = 1'b0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;
    int          stall_len;
    t_fraction   next_fraction;
    t_reduced    oldest;

    always #2 i_clk = ~i_clk;

    // Expected reduced fraction: Euclid on the ordered pair, then divide both parts.
    function automatic t_reduced reduce_fraction(logic [W-1:0] num, logic [W-1:0] den);
        logic [W-1:0] greater;
        logic [W-1:0] lesser;
        logic [W-1:0] remainder;
        t_reduced     res;
        res = '0;
        if (num == '0 || den == '0) begin
            res.zero_operand_error = 1'b1;
            return res;
        end
        greater = (num > den) ? num : den;
        lesser  = (num > den) ? den : num;
        while (lesser != '0) begin
            remainder = greater % lesser;
            greater   = lesser;
            lesser    = remainder;
        end
        res.reduced_numerator   = OUT_W'(num / greater);
        res.reduced_denominator = OUT_W'(den / greater);
        return res;
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches of no idling.
    function automatic int draw_gap(inout int calm_left);
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_fraction(logic [W-1:0] num, logic [W-1:0] den);
        t_fraction f;
        f.numerator   = num;
        f.denominator = den;
        pending_fractions.push_back(f);
    endtask

    task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input driver: a new beat goes out at the falling edge once the previous one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_ch.valid || item_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                item_ch.valid <= 1'b0;
            end else if (pending_fractions.size() > 0) begin
                next_fraction = pending_fractions.pop_front();
                item_ch.numerator <= next_fraction.numerator;
                item_ch.denominator <= next_fraction.denominator;
                item_ch.valid <= 1'b1;
                send_gap <= draw_gap(send_calm);
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: stalls follow a taken beat or start at random in any phase.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end else if (result_taken || $urandom_range(0, 15) == 0) begin
                stall_len = draw_gap(stall_calm);
                if (stall_len > 0) begin
                    stall_left <= stall_len - 1;
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: record accepted fractions and check every result beat in order.
    always @(posedge i_clk) begin
        item_taken   <= i_rst_n && item_ch.valid && item_ch.ready;
        result_taken <= i_rst_n && result_ch.valid && result_ch.ready;
        if (i_rst_n && item_ch.valid && item_ch.ready)
            expected_reductions.push_back(
                reduce_fraction(item_ch.numerator, item_ch.denominator));
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_reductions.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0h/%0h err %0b",
                         $time, result_ch.reduced_numerator, result_ch.reduced_denominator,
                         result_ch.zero_operand_error);
                error_count++;
            end else begin
                oldest = expected_reductions.pop_front();
                check_field("reduced_numerator", oldest.reduced_numerator,
                            result_ch.reduced_numerator);
                check_field("reduced_denominator", oldest.reduced_denominator,
                            result_ch.reduced_denominator);
                check_field("zero_operand_error", OUT_W'(oldest.zero_operand_error),
                            OUT_W'(result_ch.zero_operand_error));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pending and %0d expected", $time,
                     pending_fractions.size(), expected_reductions.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned  g;
        int unsigned  m;
        int           idx;
        int           pick;
        logic [W-1:0] a;
        logic [W-1:0] b;

        item_ch.valid       = 1'b0;
        item_ch.numerator   = '0;
        item_ch.denominator = '0;
        result_ch.ready     = 1'b0;

        fib[0] = 1;
        fib[1] = 1;
        for (int i = 2; i < 48; i++)
            fib[i] = fib[i-1] + fib[i-2];

        // Directed fractions: zero operands, equal operands, extremes, ordering, deep Euclid.
        add_fraction('0, 32'd5);
        add_fraction(32'd7, '0);
        add_fraction('0, '0);
        add_fraction('0, '1);
        add_fraction('1, '0);
        add_fraction(32'd1, 32'd1);
        add_fraction('1, '1);
        add_fraction(32'd1234567, 32'd1234567);
        add_fraction(32'd1, '1);
        add_fraction('1, 32'd1);
        add_fraction('1, 32'hFFFF_FFFE);
        add_fraction(32'h8000_0000, 32'h4000_0000);
        add_fraction(32'h4000_0000, 32'h8000_0000);
        add_fraction(32'd12, 32'd18);
        add_fraction(32'd18, 32'd12);
        add_fraction(fib[46], fib[45]);
        add_fraction(fib[45], fib[46]);
        add_fraction(32'd4294967291, 32'd65521);
        add_fraction(32'hAAAA_AAAA, 32'h5555_5555);
        add_fraction(32'h5555_5555, 32'hAAAA_AAAA);
        add_fraction(32'hFFFF_0000, 32'h0000_FFFF);

        // Random fractions of several shapes.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                a = ($urandom_range(0, 1) == 1) ? '0 : W'($urandom);
                b = (a == '0) ? W'($urandom_range(0, 3)) : '0;
            end else if (pick < 8) begin
                a = $urandom;
                b = a;
            end else if (pick < 20) begin
                a = $urandom_range(1, 255);
                b = $urandom_range(1, 255);
            end else if (pick < 45) begin
                g = $urandom_range(2, 100000);
                a = $urandom_range(1, 32'hFFFF_FFFF / g) * g;
                b = $urandom_range(1, 32'hFFFF_FFFF / g) * g;
            end else if (pick < 55) begin
                idx = $urandom_range(2, 45);
                m   = $urandom_range(1, 32'hFFFF_FFFF / fib[idx+1]);
                a   = fib[idx+1] * m;
                b   = fib[idx] * m;
                if ($urandom_range(0, 1) == 1) begin
                    a = fib[idx] * m;
                    b = fib[idx+1] * m;
                end
            end else begin
                a = $urandom;
                b = $urandom;
            end
            add_fraction(a, b);
        end

        // Synchronous reset, released on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_fractions.size() != 0 || item_ch.valid)
            @(posedge i_clk);
        while (expected_reductions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
